[hw/rtl/text_console_writer_assert.svh]
// Assertion macros for the text console writer
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("text console writer check failed");
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("text console writer check failed");
`else
`define TCW_ASSERT(lbl, prop)
`define TCW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/tcw_pkg.sv]
// Types and constants shared by the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned COPY_COUNT = COLUMNS * (ROWS - 1);

  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CELL_W = CHAR_W + ATTR_W;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned ADDR_W = $clog2(CELL_COUNT);

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_type_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_line;
  } rsp_t;

endpackage

[hw/rtl/tcw_ram.sv]
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/text_console_writer.sv]
// Top level of the text console writer: request sequencer around the screen RAM
//
// Channel  Direction  Signals                           Item
// in       in         in_valid_i in_ready_o in_item_i   req_t (put, clear, read)
// out      out        out_valid_o out_ready_i out_item_o rsp_t (cell, cursor)
// cfg      in         cfg_valid_i cfg_ready_o cfg_data_i text attribute byte
//
// After reset the screen RAM is blanked one cell a cycle, all 2000 cells, no item taken.
// Put without line change and any read: ST_EXEC, ST_RD_WAIT for an in-range read, ST_DONE.
// Line change past the bottom row: ST_SCROLL copies a cell a cycle for 1920 cells on one
// RAM port pair, then ST_BLANK writes 80 blanks. Clear: ST_BLANK blanks all 2000 cells.
// A waiting result does not block the next accept; the config port is always ready.
`timescale 1ns / 1ps
`include "text_console_writer_assert.svh"

module text_console_writer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  tcw_pkg::req_t             in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tcw_pkg::rsp_t             out_item_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_data_i
);

  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SCROLL,
    ST_BLANK,
    ST_DONE
  } state_e;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              cp_vld_q, cp_vld_d;
  logic [ATTR_W-1:0] attr_q, attr_d;
  logic [CHAR_W-1:0] rd_char_q, rd_char_d;
  logic [ATTR_W-1:0] rd_attr_q, rd_attr_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  logic [ADDR_W-1:0] cell_addr;

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_COUNT)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cell_addr = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    col_d       = col_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    cp_vld_d    = cp_vld_q;
    attr_d      = attr_q;
    rd_char_d   = rd_char_q;
    rd_attr_d   = rd_attr_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    if (cfg_valid_i) begin
      attr_d = cfg_data_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {RESET_ATTR, BLANK_CHAR};
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_item_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rd_char_d = '0;
        rd_attr_d = '0;
        state_d   = ST_DONE;
        case (req_q.req_type)
          REQ_PUT: begin
            if (req_q.char_code != NEWLINE_CHAR) begin
              ram_we    = 1'b1;
              ram_waddr = cell_addr;
              ram_wdata = {attr_q, req_q.char_code};
            end
            if (req_q.char_code == NEWLINE_CHAR || col_q == COL_W'(COLUMNS - 1)) begin
              col_d = '0;
              if (row_q == ROW_W'(ROWS - 1)) begin
                cnt_d    = '0;
                cp_vld_d = 1'b0;
                state_d  = ST_SCROLL;
              end else begin
                row_d = row_q + 1'b1;
              end
            end else begin
              col_d = col_q + 1'b1;
            end
          end
          REQ_CLEAR: begin
            cnt_d   = '0;
            state_d = ST_BLANK;
          end
          REQ_READ: begin
            if (req_q.cell_index < IDX_W'(CELL_COUNT)) begin
              ram_re    = 1'b1;
              ram_raddr = ADDR_W'(req_q.cell_index);
              state_d   = ST_RD_WAIT;
            end
          end
          default: begin
          end
        endcase
      end
      ST_RD_WAIT: begin
        rd_char_d = ram_rdata[CHAR_W-1:0];
        rd_attr_d = ram_rdata[CELL_W-1:CHAR_W];
        state_d   = ST_DONE;
      end
      ST_SCROLL: begin
        if (cp_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (cnt_q == ADDR_W'(COPY_COUNT)) begin
          cp_vld_d = 1'b0;
          state_d  = ST_BLANK;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q + ADDR_W'(COLUMNS);
          cp_vld_d  = 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end
      end
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {attr_q, BLANK_CHAR};
        if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = '{cell_char: rd_char_q, cell_attr: rd_attr_q,
                          cursor_column: col_q, cursor_line: row_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      req_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      cp_vld_q    <= 1'b0;
      attr_q      <= RESET_ATTR;
      rd_char_q   <= '0;
      rd_attr_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      col_q       <= col_d;
      row_q       <= row_d;
      cnt_q       <= cnt_d;
      cp_vld_q    <= cp_vld_d;
      attr_q      <= attr_d;
      rd_char_q   <= rd_char_d;
      rd_attr_q   <= rd_attr_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `TCW_ASSERT(a_col_range, col_q < COL_W'(COLUMNS))
  `TCW_ASSERT(a_row_range, row_q < ROW_W'(ROWS))
  `TCW_ASSERT(a_no_rw_clash, !(ram_we && ram_re && ram_waddr == ram_raddr))
  `TCW_ASSERT(a_scroll_dst, !(state_q == ST_SCROLL && ram_we) || ram_waddr < ADDR_W'(COPY_COUNT))
  `TCW_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

endmodule

[tb/sv/text_console_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the text console writer: mirrors screen, cursor and attribute, checks results
module text_console_checker
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  req_t              in_item_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  rsp_t              out_item_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [ATTR_W-1:0] cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int MAX_REPORTS = 10;

  logic [CELL_W-1:0] screen [CELL_COUNT];
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [ATTR_W-1:0] text_attr;
  rsp_t              awaited_reports [$];
  int                fails = 0;
  int                pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic void log_failure(string msg);
    fails++;
    if (fails <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void blank_cells(int unsigned first, int unsigned count);
    for (int unsigned i = first; i < first + count; i++)
      screen[ADDR_W'(i)] = {text_attr, BLANK_CHAR};
  endfunction

  function automatic void line_feed();
    cursor_col = '0;
    if (cursor_row == ROWS - 1) begin
      for (int unsigned i = 0; i < COPY_COUNT; i++)
        screen[ADDR_W'(i)] = screen[ADDR_W'(i + COLUMNS)];
      blank_cells(COPY_COUNT, COLUMNS);
    end else begin
      cursor_row++;
    end
  endfunction

  function automatic rsp_t console_step(req_t r);
    rsp_t res;
    res = '0;
    case (r.req_type)
      REQ_PUT: begin
        if (r.char_code == NEWLINE_CHAR) begin
          line_feed();
        end else begin
          screen[ADDR_W'(cursor_row * COLUMNS + cursor_col)] = {text_attr, r.char_code};
          if (cursor_col == COLUMNS - 1) line_feed();
          else cursor_col++;
        end
      end
      REQ_CLEAR: begin
        blank_cells(0, CELL_COUNT);
      end
      REQ_READ: begin
        if (r.cell_index < CELL_COUNT) begin
          res.cell_char = screen[r.cell_index][CHAR_W-1:0];
          res.cell_attr = screen[r.cell_index][CELL_W-1:CHAR_W];
        end
      end
      default: begin
      end
    endcase
    res.cursor_column = cursor_col;
    res.cursor_line   = cursor_row;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      text_attr  = RESET_ATTR;
      blank_cells(0, CELL_COUNT);
      cursor_col = '0;
      cursor_row = '0;
      awaited_reports.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_reports.size() == 0) begin
          log_failure($sformatf("result with none expected: char %0h attr %0h col %0d line %0d",
                                out_item_i.cell_char, out_item_i.cell_attr,
                                out_item_i.cursor_column, out_item_i.cursor_line));
        end else begin
          want = awaited_reports.pop_front();
          if (out_item_i.cell_char !== want.cell_char)
            log_failure($sformatf("cell_char expected %0h, got %0h",
                                  want.cell_char, out_item_i.cell_char));
          if (out_item_i.cell_attr !== want.cell_attr)
            log_failure($sformatf("cell_attr expected %0h, got %0h",
                                  want.cell_attr, out_item_i.cell_attr));
          if (out_item_i.cursor_column !== want.cursor_column)
            log_failure($sformatf("cursor_column expected %0d, got %0d",
                                  want.cursor_column, out_item_i.cursor_column));
          if (out_item_i.cursor_line !== want.cursor_line)
            log_failure($sformatf("cursor_line expected %0d, got %0d",
                                  want.cursor_line, out_item_i.cursor_line));
        end
      end
      if (cfg_valid_i && cfg_ready_i) text_attr = cfg_data_i;
      if (in_valid_i && in_ready_i) awaited_reports.push_back(console_step(in_item_i));
    end
    pending = awaited_reports.size();
  end

endmodule

[tb/sv/text_console_writer_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the text console writer: clock, reset, stimulus, flow control and verdict
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int unsigned REQ_W        = $bits(req_t);
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned PHASES       = 5;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned IDLE_PCT     = 21;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned DRAIN        = 50;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  req_t              in_item_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  rsp_t              out_item_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [ATTR_W-1:0] cfg_data_i  = '0;
  int                fail_count;
  int                pending_count;
  bit                calm        = 1'b0;
  bit                hold_req    = 1'b0;
  int unsigned       counted_items = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  text_console_writer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  text_console_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  function automatic req_t make_req(logic [1:0] kind, logic [CHAR_W-1:0] ch,
                                    logic [IDX_W-1:0] idx);
    req_t r;
    r.req_type   = kind;
    r.char_code  = ch;
    r.cell_index = idx;
    return r;
  endfunction

  task automatic offer(input req_t r);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    if (r.req_type != REQ_UNUSED) counted_items++;
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] value);
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_burst();
    int unsigned pick;
    int unsigned len;
    logic [IDX_W-1:0] idx;
    logic [$bits(req_t)-1:0] raw;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      len = ($urandom_range(0, 99) < 15) ? $urandom_range(70, 100) : $urandom_range(0, 12);
      repeat (len) offer(make_req(REQ_PUT, CHAR_W'($urandom), IDX_W'($urandom)));
      if ($urandom_range(0, 99) < 80) offer(make_req(REQ_PUT, NEWLINE_CHAR, IDX_W'($urandom)));
    end else if (pick < 70) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 1) != 0) idx = IDX_W'($urandom);
        else idx = IDX_W'($urandom_range(CELL_COUNT - 1, CELL_COUNT - 3 * COLUMNS));
        offer(make_req(REQ_READ, CHAR_W'($urandom), idx));
      end
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 4)) offer(make_req(REQ_PUT, NEWLINE_CHAR, IDX_W'($urandom)));
    end else if (pick < 90) begin
      offer(make_req(REQ_CLEAR, CHAR_W'($urandom), IDX_W'($urandom)));
    end else if (pick < 94) begin
      offer(make_req(REQ_UNUSED, CHAR_W'($urandom), IDX_W'($urandom)));
    end else begin
      raw = REQ_W'($urandom);
      offer(raw);
    end
  endtask

  initial begin : rsp_sink
    int unsigned hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [ATTR_W-1:0] phase_attr [PHASES];
    int unsigned target;
    phase_attr    = '{8'hFF, 8'h00, 8'h00, 8'hF0, 8'h00};
    phase_attr[2] = ATTR_W'($urandom);
    phase_attr[4] = ATTR_W'($urandom);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);

    offer(make_req(REQ_READ, 8'h00, '0));
    offer(make_req(REQ_READ, 8'hFF, IDX_W'(CELL_COUNT - 1)));
    offer(make_req(REQ_READ, 8'h00, IDX_W'(CELL_COUNT)));
    offer(make_req(REQ_READ, 8'h00, '1));
    offer(make_req(REQ_PUT, 8'h00, '0));
    offer(make_req(REQ_PUT, 8'hFF, '1));
    offer(make_req(REQ_PUT, 8'h0D, '0));
    offer(make_req(REQ_PUT, NEWLINE_CHAR, '0));
    offer(make_req(REQ_PUT, 8'h41, '0));
    offer(make_req(REQ_UNUSED, 8'hFF, '1));
    offer(make_req(REQ_READ, 8'h00, '0));
    offer(make_req(REQ_READ, 8'h00, 11'd1));
    offer(make_req(REQ_READ, 8'h00, IDX_W'(COLUMNS)));
    in_valid_i <= 1'b0;
    write_attr(8'hA5);
    offer(make_req(REQ_CLEAR, 8'h00, '0));
    offer(make_req(REQ_READ, 8'h00, '0));
    offer(make_req(REQ_READ, 8'h00, IDX_W'(CELL_COUNT - 1)));
    offer(make_req(REQ_PUT, 8'h42, '0));
    offer(make_req(REQ_READ, 8'h00, IDX_W'(COLUMNS + 1)));

    for (int p = 0; p < PHASES; p++) begin
      in_valid_i <= 1'b0;
      write_attr(phase_attr[p]);
      calm   = (p == 1);
      target = counted_items + RANDOM_ITEMS / PHASES;
      while (counted_items < target) begin
        if (p == 3 && !hold_req && counted_items + 40 > target) hold_req = 1'b1;
        send_burst();
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
